[hw/rtl/esp_pkg.sv]
// Shared types and constants for the encoder position and speed estimator.
// No dependencies; imported by esp_mul, esp_div and the top level.
`timescale 1ns / 1ps

package esp_pkg;

	localparam int DEN_W = 48;
	localparam int POS_W = 40;

	typedef logic signed [32:0] mul_op_t;
	typedef logic signed [65:0] mul_prod_t;

	localparam logic [25:0] RPM_NUMERATOR  = 26'd60000000;
	localparam logic [28:0] PI_OVER_30_Q32 = 29'd449767923;
	localparam logic [31:0] PERIOD_RESET   = 32'd2000000000;
	localparam logic [30:0] SPEED_MAX      = 31'h7FFFFFFF;
	localparam logic [16:0] EMA_ONE        = 17'd65536;

	localparam logic [15:0] PPR_RESET = 16'd4191;
	localparam logic [23:0] DPP_RESET = 24'd1441136;
	localparam logic [15:0] EMA_RESET = 16'd19661;

	localparam logic [1:0] CFG_PPR = 2'd0;
	localparam logic [1:0] CFG_DPP = 2'd1;
	localparam logic [1:0] CFG_EMA = 2'd2;

endpackage

[hw/rtl/encoder_position_speed_estimator.sv]
// Encoder position and speed estimator, top level with the sample sequencer.
// Edge item: one item per cycle while the sequencer is idle. Sample item: holds
// in_ready low until its result is loaded, waiting in S_DONE while out_valid is
// held without out_ready; the restoring divider yields one quotient bit per cycle.
// Reset (arst_n low) restores registers and state to their reset values at once.
`timescale 1ns / 1ps

module encoder_position_speed_estimator #(
	parameter int COUNT_WIDTH     = 24,
	parameter int SPEED_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic               level_a,
	input  logic               level_b,
	input  logic [31:0]        time_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [39:0] position_deg,
	output logic signed [31:0] revolutions,
	output logic signed [31:0] speed_rpm,
	output logic signed [31:0] speed_rad_per_s
);
	import esp_pkg::*;

	localparam int NUM_W = 26 + SPEED_FRAC_BITS;
	localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
	localparam logic [NUM_W-1:0] DIV_NUM = NUM_W'(RPM_NUMERATOR) << SPEED_FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_POS, S_DEN, S_DIVS, S_DIVW, S_EMA1, S_EMA2, S_EMA3, S_RAD, S_RADC, S_DONE
	} state_t;

	state_t                        state_q;
	logic [15:0]                   ppr_q;
	logic [23:0]                   dpp_q;
	logic [15:0]                   ema_q;
	logic signed [COUNT_WIDTH-1:0] count_q;
	logic                          fwd_q;
	logic [31:0]                   last_q;
	logic [31:0]                   period_q;
	logic [31:0]                   rev_q;
	logic signed [31:0]            filt_q;
	logic [COUNT_WIDTH-1:0]        mag_q;
	logic                          neg_q;
	logic [POS_W-1:0]              pm_q;
	logic signed [31:0]            raw_q;
	mul_prod_t                     p1_q;
	logic signed [31:0]            rad_q;
	logic                          out_valid_q;
	logic [POS_W-1:0]              pos_out_q;
	logic [31:0]                   rev_out_q;
	logic signed [31:0]            rpm_out_q;
	logic signed [31:0]            rad_out_q;

	mul_op_t          mul_a;
	mul_op_t          mul_b;
	mul_prod_t        prod;
	logic             div_start;
	logic             div_done;
	logic [NUM_W-1:0] div_quo;

	logic signed [33:0]       cnt_x;
	logic signed [33:0]       ppr_x;
	logic                     rev_up;
	logic                     rev_dn;
	logic [16:0]              ema_rest;
	mul_prod_t                pos_rnd;
	mul_prod_t                ema_sum;
	mul_prod_t                rad_sum;
	logic                     quo_sat;
	logic [30:0]              spd_mag;
	logic signed [31:0]       raw_next;
	logic                     accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign div_start = (state_q == S_DIVS);

	assign cnt_x    = 34'(count_q);
	assign ppr_x    = $signed({18'b0, ppr_q});
	assign rev_up   = fwd_q && (cnt_x >= ppr_x);
	assign rev_dn   = !fwd_q && (cnt_x <= -ppr_x);
	assign ema_rest = EMA_ONE - 17'(ema_q);

	assign pos_rnd = prod + 66'sd128;
	assign ema_sum = p1_q + prod + 66'sd32768;
	assign rad_sum = prod + 66'sh80000000;

	assign quo_sat  = |div_quo[NUM_W-1:31];
	assign spd_mag  = quo_sat ? SPEED_MAX : div_quo[30:0];
	assign raw_next = fwd_q ? $signed({1'b0, spd_mag}) : -$signed({1'b0, spd_mag});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_POS: begin
				mul_a = $signed(33'(mag_q));
				mul_b = $signed(33'(dpp_q));
			end
			S_DEN: begin
				mul_a = $signed(33'(ppr_q));
				mul_b = $signed(33'(period_q));
			end
			S_EMA1: begin
				mul_a = 33'(raw_q);
				mul_b = $signed(33'(ema_q));
			end
			S_EMA2: begin
				mul_a = 33'(filt_q);
				mul_b = $signed(33'(ema_rest));
			end
			S_RAD: begin
				mul_a = 33'(filt_q);
				mul_b = $signed(33'(PI_OVER_30_Q32));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	esp_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	esp_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (DIV_NUM),
		.den    (prod[DEN_W-1:0]),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ppr_q       <= PPR_RESET;
			dpp_q       <= DPP_RESET;
			ema_q       <= EMA_RESET;
			count_q     <= '0;
			fwd_q       <= 1'b0;
			last_q      <= '0;
			period_q    <= PERIOD_RESET;
			rev_q       <= '0;
			filt_q      <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			pm_q        <= '0;
			raw_q       <= '0;
			p1_q        <= '0;
			rad_q       <= '0;
			out_valid_q <= 1'b0;
			pos_out_q   <= '0;
			rev_out_q   <= '0;
			rpm_out_q   <= '0;
			rad_out_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PPR: ppr_q <= cfg_data[15:0];
					CFG_DPP: dpp_q <= cfg_data;
					CFG_EMA: ema_q <= cfg_data[15:0];
					default: ;
				endcase
			end

			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!func) begin
							if (level_a == level_b) begin
								if (count_q != COUNT_MAX)
									count_q <= count_q + COUNT_WIDTH'(1);
								fwd_q <= 1'b1;
							end else begin
								if (count_q != COUNT_MIN)
									count_q <= count_q - COUNT_WIDTH'(1);
								fwd_q <= 1'b0;
							end
							period_q <= time_us - last_q;
							last_q   <= time_us;
						end else begin
							mag_q <= count_q[COUNT_WIDTH-1] ? COUNT_WIDTH'(-count_q)
							                                : COUNT_WIDTH'(count_q);
							neg_q <= count_q[COUNT_WIDTH-1];
							if (rev_up) begin
								rev_q   <= rev_q + 32'd1;
								count_q <= '0;
							end else if (rev_dn) begin
								rev_q   <= rev_q - 32'd1;
								count_q <= '0;
							end
							state_q <= S_POS;
						end
					end
				end
				S_POS: state_q <= S_DEN;
				S_DEN: begin
					pm_q    <= pos_rnd[POS_W+7:8];
					state_q <= S_DIVS;
				end
				S_DIVS: state_q <= S_DIVW;
				S_DIVW: begin
					if (div_done) begin
						raw_q   <= raw_next;
						state_q <= S_EMA1;
					end
				end
				S_EMA1: state_q <= S_EMA2;
				S_EMA2: begin
					p1_q    <= prod;
					state_q <= S_EMA3;
				end
				S_EMA3: begin
					filt_q  <= ema_sum[47:16];
					state_q <= S_RAD;
				end
				S_RAD: state_q <= S_RADC;
				S_RADC: begin
					rad_q   <= rad_sum[63:32];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						pos_out_q   <= neg_q ? -pm_q : pm_q;
						rev_out_q   <= rev_q;
						rpm_out_q   <= filt_q;
						rad_out_q   <= rad_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign position_deg    = $signed(pos_out_q);
	assign revolutions     = $signed(rev_out_q);
	assign speed_rpm       = rpm_out_q;
	assign speed_rad_per_s = rad_out_q;

`ifndef NO_ASSERTIONS
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func |=> !in_ready)
		else $error("sample item did not start the sequencer");

	a_edge_ready: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !func |=> in_ready)
		else $error("edge item left the block busy");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIVW)
		else $error("divider finished outside the wait state");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result raised without a finished sample");

	a_rev_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func && rev_up |=> count_q == '0 && rev_q == $past(rev_q) + 32'd1)
		else $error("forward revolution step missed");
`endif

endmodule

[hw/rtl/esp_mul.sv]
// Shared signed 33x33 multiplier with a registered product.
// Depends on esp_pkg for the operand and product types.
`timescale 1ns / 1ps

module esp_mul (
	input  logic               clk,
	input  esp_pkg::mul_op_t   a,
	input  esp_pkg::mul_op_t   b,
	output esp_pkg::mul_prod_t prod
);
	import esp_pkg::*;

	mul_prod_t prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

[hw/rtl/esp_div.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on esp_pkg for the divisor width.
`timescale 1ns / 1ps

module esp_div #(
	parameter int NUM_W = 42
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [NUM_W-1:0]          num,
	input  logic [esp_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [NUM_W-1:0]          quo
);
	import esp_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (!diff[DEN_W+1]) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DEN_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[sim/tb_encoder_position_speed_estimator.sv]
// Testbench for encoder_position_speed_estimator: directed and random edge and sample
// items, with the expected samples predicted in a small scoreboard class.
// Depends on esp_pkg and the encoder_position_speed_estimator top level only.
`timescale 1ns / 1ps

import esp_pkg::*;

typedef struct packed {
	logic signed [39:0] position;
	logic signed [31:0] revs;
	logic signed [31:0] rpm;
	logic signed [31:0] rad;
} sample_result_t;

class speed_scoreboard;
	longint ppr, dpp, ema;
	longint count, count_hi, count_lo;
	bit forward;
	logic [31:0] last_time, period, revs;
	int filtered;
	sample_result_t expected_samples[$];
	int errors;

	function new();
		ppr = PPR_RESET;
		dpp = DPP_RESET;
		ema = EMA_RESET;
		count_hi = (longint'(1) << 23) - 1;
		count_lo = -(longint'(1) << 23);
		count = 0;
		forward = 1'b0;
		last_time = '0;
		period = PERIOD_RESET;
		revs = '0;
		filtered = 0;
		errors = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [23:0] val);
		case (idx)
			CFG_PPR: ppr = val[15:0];
			CFG_DPP: dpp = val;
			CFG_EMA: ema = val[15:0];
			default: ;
		endcase
	endfunction

	function void note_item(bit f, bit a, bit b, logic [31:0] t);
		sample_result_t r;
		longint mag, raw, acc;
		logic [63:0] den, quot;
		logic [39:0] pm;
		if (!f) begin
			if (a == b) begin
				if (count < count_hi) count++;
				forward = 1'b1;
			end else begin
				if (count > count_lo) count--;
				forward = 1'b0;
			end
			period = t - last_time;
			last_time = t;
			return;
		end
		// position uses the count before the revolution step
		mag = (count < 0) ? -count : count;
		pm = 40'((mag * dpp + 128) >> 8);
		r.position = (count < 0) ? -pm : pm;
		if (forward) begin
			if (count >= ppr) begin
				revs++;
				count = 0;
			end
		end else if (count <= -ppr) begin
			revs--;
			count = 0;
		end
		r.revs = revs;
		den = 64'(ppr) * 64'(period);
		if (den == 0) begin
			raw = longint'(SPEED_MAX);
		end else begin
			quot = (64'(RPM_NUMERATOR) << 16) / den;
			if (quot > 64'(SPEED_MAX)) raw = longint'(SPEED_MAX);
			else raw = longint'(quot);
		end
		if (!forward) raw = -raw;
		acc = ema * raw + (65536 - ema) * longint'(filtered) + 32768;
		filtered = int'(acc >>> 16);
		r.rpm = filtered;
		acc = longint'(filtered) * longint'(PI_OVER_30_Q32) + (longint'(1) << 31);
		r.rad = 32'(acc >>> 32);
		expected_samples.push_back(r);
	endfunction

	function void check_result(sample_result_t got);
		sample_result_t want;
		if (expected_samples.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("%0t: result with no sample pending: pos %0d rev %0d rpm %0d rad %0d",
					$realtime, got.position, got.revs, got.rpm, got.rad);
			return;
		end
		want = expected_samples.pop_front();
		if (got.position !== want.position || got.revs !== want.revs ||
				got.rpm !== want.rpm || got.rad !== want.rad) begin
			errors++;
			if (errors <= 10)
				$display("%0t: exp pos %0d rev %0d rpm %0d rad %0d, got pos %0d rev %0d rpm %0d rad %0d",
					$realtime, want.position, want.revs, want.rpm, want.rad,
					got.position, got.revs, got.rpm, got.rad);
		end
	endfunction

	function bit pending();
		return expected_samples.size() != 0;
	endfunction
endclass

module tb_encoder_position_speed_estimator;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 64;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [1:0]         cfg_index = CFG_PPR;
	logic [23:0]        cfg_data  = '0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic               func      = 1'b0;
	logic               level_a   = 1'b0;
	logic               level_b   = 1'b0;
	logic [31:0]        time_us   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [39:0] position_deg;
	logic signed [31:0] revolutions;
	logic signed [31:0] speed_rpm;
	logic signed [31:0] speed_rad_per_s;

	speed_scoreboard sb = new();
	int tx_idle = 0;
	int rx_idle = 0;
	int cycles = 0;
	logic [31:0] now_us = '0;
	bit run_fwd = 1'b1;
	int run_left = 0;

	encoder_position_speed_estimator i_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL encoder_position_speed_estimator");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({position_deg, revolutions, speed_rpm, speed_rad_per_s});
		out_ready <= ($urandom_range(99) >= rx_idle);
	end

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(input logic [15:0] p, input logic [23:0] d, input logic [15:0] e);
		write_reg(CFG_PPR, 24'(p));
		write_reg(CFG_DPP, d);
		write_reg(CFG_EMA, 24'(e));
		cfg_we <= 1'b0;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (sb.pending()) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_item(input bit f, input bit a, input bit b, input logic [31:0] t);
		int gap = 0;
		while ($urandom_range(99) < tx_idle) gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		level_a <= a;
		level_b <= b;
		time_us <= t;
		do @(posedge clk); while (!in_ready);
		sb.note_item(f, a, b, t);
	endtask

	task automatic random_traffic(input int n);
		int pick;
		bit a;
		bit flip;
		repeat (n) begin
			pick = $urandom_range(99);
			a = 1'($urandom_range(1));
			if (pick < 8) begin
				send_item(1'($urandom_range(1)), a, 1'($urandom_range(1)), $urandom());
			end else if (pick < 28) begin
				send_item(1'b1, a, 1'($urandom_range(1)), $urandom());
			end else begin
				// advance a run of edges in one direction, with stray reversals
				if (run_left == 0) begin
					run_fwd = 1'($urandom_range(1));
					run_left = $urandom_range(1, 40);
				end
				run_left--;
				pick = $urandom_range(99);
				if (pick >= 10) now_us += $urandom_range(1, 3000);
				else if (pick >= 5) now_us += $urandom();
				flip = ($urandom_range(99) < 6);
				send_item(1'b0, a, (run_fwd ^ flip) ? a : !a, now_us);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle = 12;
		rx_idle = 46;
		send_item(1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
		send_item(1'b0, 1'b0, 1'b0, 32'd0);
		send_item(1'b1, 1'b1, 1'b1, 32'd0);
		send_item(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_item(1'b0, 1'b1, 1'b1, 32'd5);
		send_item(1'b1, 1'b0, 1'b1, 32'h5555_5555);
		send_item(1'b0, 1'b0, 1'b1, 32'd105);
		send_item(1'b0, 1'b1, 1'b0, 32'd1105);
		send_item(1'b0, 1'b0, 1'b1, 32'd1106);
		send_item(1'b0, 1'b1, 1'b0, 32'd1106);
		send_item(1'b1, 1'b1, 1'b0, 32'hAAAA_AAAA);
		drain;
		configure(16'd1, 24'hFF_FFFF, 16'hFFFF);
		send_item(1'b0, 1'b1, 1'b1, 32'd2000);
		send_item(1'b0, 1'b0, 1'b0, 32'd2001);
		send_item(1'b1, 1'b0, 1'b0, 32'd0);
		send_item(1'b0, 1'b1, 1'b0, 32'd2002);
		send_item(1'b0, 1'b0, 1'b1, 32'd2003);
		send_item(1'b1, 1'b0, 1'b0, 32'd0);
		drain;
		configure(16'd0, 24'd0, 16'd0);
		send_item(1'b1, 1'b0, 1'b0, 32'd0);
		send_item(1'b0, 1'b1, 1'b1, 32'd9000);
		send_item(1'b1, 1'b0, 1'b0, 32'd0);
		drain;
		configure(16'hFFFF, 24'd1, 16'd1);
		send_item(1'b0, 1'b0, 1'b0, 32'd9500);
		send_item(1'b1, 1'b1, 1'b1, 32'd0);
		now_us = 32'd9500;

		for (int seg = 0; seg < 6; seg++) begin
			drain;
			case (seg / 2)
				0: begin
					tx_idle = 12;
					rx_idle = 46;
				end
				1: begin
					tx_idle = 46;
					rx_idle = 12;
				end
				default: begin
					tx_idle = 0;
					rx_idle = 0;
				end
			endcase
			case (seg)
				0: configure(PPR_RESET, DPP_RESET, EMA_RESET);
				1: configure(16'd1, 24'hFF_FFFF, 16'hFFFF);
				2: configure(16'hFFFF, 24'd0, 16'd0);
				default: configure(16'($urandom_range(1, 12)), 24'($urandom()),
					16'($urandom_range(0, 65535)));
			endcase
			random_traffic(215);
		end

		drain;
		if (sb.errors == 0 && !sb.pending())
			$display("PASS encoder_position_speed_estimator");
		else
			$display("FAIL encoder_position_speed_estimator");
		$finish;
	end
endmodule
